// File: hdl/hfts_pkg.sv
// Package with the shared constants and types of the hit time sorter.
`timescale 1ns / 1ps
package hfts_pkg;
  localparam int MAX_HITS = 64;
  localparam int ADDR_W = $clog2(MAX_HITS);
  localparam int CNT_W = $clog2(MAX_HITS + 1);
  localparam int CH_W = 12;
  localparam int FL_W = 32;
  localparam int TIME_W = 40;
  localparam int Q_W = 24;
  localparam int LOST_W = 16;
  localparam int HIT_W = CH_W + TIME_W + Q_W;

  typedef struct packed {
    logic [CH_W-1:0] channel;
    logic signed [TIME_W-1:0] hit_time;
    logic signed [Q_W-1:0] charge;
  } hit_t;
endpackage

// File: hdl/hfts_ram.sv
// Generic simple dual port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module hfts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: hdl/hit_filter_time_sorter.sv
// Top level of the hit filter and time sorter.
`timescale 1ns / 1ps
// Hits are inserted into a sorted store kept in one RAM. A dropped hit (flags set,
// time not above zero, or store full) is not stored. A kept hit goes to entry zero
// when the store is empty; else the last entry is read, each entry with a greater
// time moves up one place, and the hit is written above the first entry whose time
// is not greater, so hits arriving in time order move no entry. The shift runs one
// RAM read and one write per cycle. After the word with end_of_set, results stream
// out one per cycle; busy stays high until the final result, and the receiver must
// take every word on the strobe.
module hit_filter_time_sorter
  import hfts_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic [CH_W-1:0] channel,
  input  logic [FL_W-1:0] flags,
  input  logic signed [TIME_W-1:0] hit_time,
  input  logic signed [Q_W-1:0] charge,
  input  logic end_of_set,
  output logic strobe,
  output logic [CH_W-1:0] out_channel,
  output logic signed [TIME_W-1:0] out_time,
  output logic signed [Q_W-1:0] out_charge,
  output logic final_result,
  output logic empty_set,
  output logic [LOST_W-1:0] dropped_hits
);
  typedef enum logic [1:0] {IDLE, SHIFT, PLACE, EMIT} state_t;
  state_t state;

  logic [CNT_W-1:0] kept_count;
  logic [LOST_W-1:0] lost_count;
  hit_t new_hit;
  logic last_pending;
  logic [ADDR_W-1:0] pos;      // entry currently read during a shift
  logic at_bottom;             // the read entry is entry zero
  logic [CNT_W-1:0] emit_idx;
  logic emit_rd;               // a read for output was issued last cycle
  logic emit_last;

  logic we;
  logic [ADDR_W-1:0] waddr, raddr;
  hit_t wdata, rdata;

  hfts_ram #(.WIDTH(HIT_W), .DEPTH(MAX_HITS)) u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  logic accept, keep;
  assign accept = start && !busy;
  assign keep = (flags == '0) && (hit_time > 0);
  assign busy = (state != IDLE);

  // In SHIFT, rdata is entry pos. Move it up if its time is greater, else place new hit.
  logic move_up;
  assign move_up = (state == SHIFT) && (rdata.hit_time > new_hit.hit_time);

  always_comb begin
    we = 1'b0;
    waddr = pos + 1'b1;
    wdata = rdata;
    raddr = pos;
    if (state == SHIFT) begin
      we = 1'b1;
      if (move_up) begin
        if (!at_bottom) begin
          raddr = pos - 1'b1;
        end
      end else begin
        wdata = new_hit;
      end
    end else if (state == PLACE) begin
      // Every stored hit moved up, so the new hit goes to entry zero.
      we = 1'b1;
      waddr = '0;
      wdata = new_hit;
    end else if (state == EMIT) begin
      raddr = emit_idx[ADDR_W-1:0];
    end else if (accept && keep && kept_count == '0) begin
      we = 1'b1;
      waddr = '0;
      wdata = '{channel: channel, hit_time: hit_time, charge: charge};
    end else begin
      raddr = ADDR_W'(kept_count - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      kept_count <= '0;
      lost_count <= '0;
      strobe <= 1'b0;
      emit_rd <= 1'b0;
      last_pending <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          strobe <= 1'b0;
          if (accept) begin
            new_hit <= '{channel: channel, hit_time: hit_time, charge: charge};
            last_pending <= end_of_set;
            emit_idx <= '0;
            emit_rd <= 1'b0;
            if (keep && kept_count == CNT_W'(MAX_HITS)) begin
              if (lost_count != '1) lost_count <= lost_count + 1'b1;
            end
            if (keep && kept_count == '0) begin
              kept_count <= CNT_W'(1);
              if (end_of_set) state <= EMIT;
            end else if (keep && kept_count != CNT_W'(MAX_HITS)) begin
              pos <= ADDR_W'(kept_count - 1'b1);
              at_bottom <= (kept_count == CNT_W'(1));
              state <= SHIFT;
            end else if (end_of_set) begin
              state <= EMIT;
            end
          end
        end
        SHIFT: begin
          strobe <= 1'b0;
          if (move_up && !at_bottom) begin
            pos <= pos - 1'b1;
            at_bottom <= (pos == ADDR_W'(1));
          end else if (move_up) begin
            state <= PLACE;
          end else begin
            kept_count <= kept_count + 1'b1;
            state <= last_pending ? EMIT : IDLE;
          end
        end
        PLACE: begin
          strobe <= 1'b0;
          kept_count <= kept_count + 1'b1;
          state <= last_pending ? EMIT : IDLE;
        end
        EMIT: begin
          if (kept_count == '0) begin
            strobe <= 1'b1;
            out_channel <= '0;
            out_time <= '0;
            out_charge <= '0;
            final_result <= 1'b1;
            empty_set <= 1'b1;
            dropped_hits <= lost_count;
            lost_count <= '0;
            state <= IDLE;
          end else begin
            if (emit_idx != kept_count) begin
              emit_idx <= emit_idx + 1'b1;
            end
            emit_rd <= (emit_idx != kept_count);
            emit_last <= (emit_idx + 1'b1 == kept_count);
            strobe <= emit_rd;
            if (emit_rd) begin
              out_channel <= rdata.channel;
              out_time <= rdata.hit_time;
              out_charge <= rdata.charge;
              final_result <= emit_last;
              empty_set <= 1'b0;
              dropped_hits <= lost_count;
              if (emit_last) begin
                kept_count <= '0;
                lost_count <= '0;
                state <= IDLE;
              end
            end
          end
        end
        default: begin
          strobe <= 1'b0;
          state <= IDLE;
        end
      endcase
    end
  end
endmodule

// File: hdl/hfts_checker.sv
// Port level checks of the hit time sorter, bound to the top level.
`timescale 1ns / 1ps
module hfts_checker
  import hfts_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic busy,
  input logic strobe,
  input logic final_result,
  input logic empty_set,
  input logic [LOST_W-1:0] dropped_hits,
  input logic signed [TIME_W-1:0] out_time
);
  a_empty_final: assert property (@(posedge clk) disable iff (rst)
    strobe && empty_set |-> final_result && out_time == '0)
    else $error("empty set word not final or time not zero");
  a_pos_time: assert property (@(posedge clk) disable iff (rst)
    strobe && !empty_set |-> out_time > 0)
    else $error("emitted hit has time not above zero");
  a_final_idle: assert property (@(posedge clk) disable iff (rst)
    strobe && final_result |-> !busy)
    else $error("busy after final word");
  a_drop_same: assert property (@(posedge clk) disable iff (rst)
    strobe && $past(strobe) && !$past(final_result) |-> $stable(dropped_hits))
    else $error("dropped count changed within a set");
  a_order: assert property (@(posedge clk) disable iff (rst)
    strobe && $past(strobe) && !$past(final_result) |-> out_time >= $past(out_time))
    else $error("output not in time order");
endmodule

bind hit_filter_time_sorter hfts_checker u_hfts_checker (
  .clk(clk), .rst(rst), .busy(busy),
  .strobe(strobe), .final_result(final_result), .empty_set(empty_set),
  .dropped_hits(dropped_hits), .out_time(out_time)
);
